/* hdl/obfs_pkg.sv */
// Shared types, codes and helpers for the order book fill simulator.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package obfs_pkg;

  localparam int unsigned MaxOrdersDef = 32;

  localparam logic [2:0] OpAdd    = 3'd0;
  localparam logic [2:0] OpCancel = 3'd1;
  localparam logic [2:0] OpReduce = 3'd2;
  localparam logic [2:0] OpQuote  = 3'd3;
  localparam logic [2:0] OpTrade  = 3'd4;
  localparam logic [2:0] OpQuery  = 3'd5;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StIgnored = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [63:0]        order_id;
    logic               is_buy;
    logic signed [63:0] price;
    logic signed [63:0] amount;
    logic signed [63:0] start_rank;
  } in_req_t;

  typedef struct packed {
    logic               is_fill;
    logic [63:0]        fill_order_id;
    logic signed [63:0] fill_price;
    logic signed [63:0] fill_quantity;
    logic [1:0]         status;
    logic               found;
    logic               last;
  } out_res_t;

  typedef struct packed {
    logic [63:0]        id;
    logic               side;
    logic signed [63:0] price;
    logic signed [63:0] quantity;
    logic signed [63:0] rank;
    logic [63:0]        arrival;
  } entry_t;

  // Saturating signed subtract a - b.
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) begin
      sat_sub = d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_sub = d[63:0];
    end
  endfunction

endpackage

/* hdl/order_book_fill_simulator_unit.sv */
// Order book fill simulator: resting order table in one synchronous memory.
// Each request scans the whole table through the single read port, then applies it;
// a quote or trade with marked entries then runs one selection scan per fill and hands
// that fill over. An undefined operation closes in the cycle after acceptance, with no
// scan. Results are held. Throughput: one request at a time. Reset: all entries invalid,
// arrival counter zero, threshold 2^63-1; no clearing pass.
`timescale 1ns / 1ps

module order_book_fill_simulator_unit
  import obfs_pkg::*;
#(
  parameter int unsigned MaxOrders = MaxOrdersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_res_t    out_data_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned IdxW = (MaxOrders > 1) ? $clog2(MaxOrders) : 1;
  localparam int unsigned CntW = $clog2(MaxOrders + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxOrders);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_SEL, S_FILL, S_CLOSE
  } state_e;

  state_e state_q;

  // Order table: payload in memory, valid/mark/trade-price flags in flops.
  entry_t mem_q [MaxOrders];
  entry_t rd_q;

  logic [MaxOrders-1:0] valid_q, mark_q, attr_q;
  logic [62:0]          thr_q;
  logic [63:0]          arrival_q;
  in_req_t              req_q;
  out_res_t             out_q;
  logic                 out_valid_q;

  // Scan counter: issue address cnt_q, process the entry read last cycle.
  logic [CntW-1:0] cnt_q;
  logic            pv_q;
  logic [IdxW-1:0] pidx_q;

  // Lookup result of the id scan.
  logic            hit_v_q;
  logic [IdxW-1:0] hit_idx_q;
  entry_t          hit_e_q;

  // Best candidate of the selection scan.
  logic            best_v_q;
  logic [IdxW-1:0] best_idx_q;
  logic [63:0]     best_price_q, best_arr_q, best_id_q, best_qty_q, best_fp_q;

  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  entry_t          mem_wd;

  logic            ev, same, at_p, tr_cross, q_cross, q_rank_upd, id_hit, better;
  logic [63:0]     new_rank, red_qty;
  logic            free_v;
  logic [IdxW-1:0] free_idx;
  logic [MaxOrders-1:0] mark_rest;
  logic            scan_done, cfg_wr;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready_o    = 1'b1;
  assign prdata_o    = (paddr_i[3] == 1'b0) ? {1'b0, thr_q} : 64'd0;
  assign cfg_wr      = psel_i & penable_i & pwrite_i & (paddr_i[3] == 1'b0);

  assign scan_done = (cnt_q == MaxCnt) && !pv_q;

  // Per-entry evaluation of the word that came back from memory.
  always_comb begin
    ev         = pv_q && valid_q[pidx_q];
    same       = (rd_q.side == req_q.is_buy);
    at_p       = (rd_q.price == req_q.price);
    tr_cross   = req_q.is_buy ? ($signed(rd_q.price) > $signed(req_q.price))
                              : ($signed(rd_q.price) < $signed(req_q.price));
    q_cross    = req_q.is_buy ? ($signed(rd_q.price) <= $signed(req_q.price))
                              : ($signed(rd_q.price) >= $signed(req_q.price));
    q_rank_upd = same && at_p && ($signed(rd_q.rank) >= $signed({1'b0, thr_q}));
    new_rank   = sat_sub(rd_q.rank, req_q.amount);
    id_hit     = ev && (rd_q.id == req_q.order_id);
    red_qty    = sat_sub(hit_e_q.quantity, req_q.amount);
    if (!best_v_q) begin
      better = 1'b1;
    end else if (rd_q.price != best_price_q) begin
      better = rd_q.side ? ($signed(rd_q.price) > $signed(best_price_q))
                         : ($signed(rd_q.price) < $signed(best_price_q));
    end else begin
      better = rd_q.arrival < best_arr_q;
    end
    mark_rest = mark_q;
    mark_rest[best_idx_q] = 1'b0;
  end

  // Lowest free slot.
  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = MaxOrders - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_v   = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // Write port: rank write-back during the scan, new or reduced entry on apply.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pidx_q;
    mem_wd = rd_q;
    if (state_q == S_SCAN && ev) begin
      if (req_q.operation == OpTrade && same && !tr_cross && at_p) begin
        mem_we      = 1'b1;
        mem_wd.rank = new_rank;
      end else if (req_q.operation == OpQuote && q_rank_upd) begin
        mem_we      = 1'b1;
        mem_wd.rank = req_q.amount;
      end
    end else if (state_q == S_APPLY) begin
      if (req_q.operation == OpAdd && !hit_v_q && free_v) begin
        mem_we = 1'b1;
        mem_wa = free_idx;
        mem_wd = '{id: req_q.order_id, side: req_q.is_buy, price: req_q.price,
                   quantity: req_q.amount, rank: req_q.start_rank,
                   arrival: arrival_q};
      end else if (req_q.operation == OpReduce && hit_v_q) begin
        mem_we          = 1'b1;
        mem_wa          = hit_idx_q;
        mem_wd          = hit_e_q;
        mem_wd.quantity = red_qty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[cnt_q[IdxW-1:0]];
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  function automatic out_res_t close_item(input logic [1:0] st, input logic fnd);
    out_res_t r;
    r        = '0;
    r.status = st;
    r.found  = fnd;
    r.last   = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      mark_q       <= '0;
      attr_q       <= '0;
      thr_q        <= '1;
      arrival_q    <= '0;
      req_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      pv_q         <= 1'b0;
      pidx_q       <= '0;
      hit_v_q      <= 1'b0;
      hit_idx_q    <= '0;
      hit_e_q      <= '0;
      best_v_q     <= 1'b0;
      best_idx_q   <= '0;
      best_price_q <= '0;
      best_arr_q   <= '0;
      best_id_q    <= '0;
      best_qty_q   <= '0;
      best_fp_q    <= '0;
    end else begin
      if (cfg_wr) begin
        thr_q <= pwdata_i[62:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            hit_v_q <= 1'b0;
            mark_q  <= '0;
            cnt_q   <= '0;
            pv_q    <= 1'b0;
            if (in_data_i.operation > OpQuery) begin
              out_q       <= close_item(StIgnored, 1'b0);
              out_valid_q <= 1'b1;
              state_q     <= S_CLOSE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt_q != MaxCnt) begin
            cnt_q <= cnt_q + 1'b1;
          end
          pv_q   <= (cnt_q != MaxCnt);
          pidx_q <= cnt_q[IdxW-1:0];
          if (id_hit && !hit_v_q) begin
            hit_v_q   <= 1'b1;
            hit_idx_q <= pidx_q;
            hit_e_q   <= rd_q;
          end
          if (ev && req_q.operation == OpTrade && same) begin
            if (tr_cross) begin
              mark_q[pidx_q] <= 1'b1;
              attr_q[pidx_q] <= 1'b0;
            end else if (at_p && new_rank[63]) begin
              mark_q[pidx_q] <= 1'b1;
              attr_q[pidx_q] <= 1'b1;
            end
          end
          if (ev && req_q.operation == OpQuote && !same && q_cross) begin
            mark_q[pidx_q] <= 1'b1;
            attr_q[pidx_q] <= 1'b0;
          end
          if (scan_done) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          unique case (req_q.operation)
            OpAdd: begin
              if (hit_v_q) begin
                out_q <= close_item(StIgnored, 1'b0);
              end else if (!free_v) begin
                out_q <= close_item(StFull, 1'b0);
              end else begin
                valid_q[free_idx] <= 1'b1;
                arrival_q         <= arrival_q + 64'd1;
                out_q             <= close_item(StDone, 1'b0);
              end
            end
            OpCancel: begin
              if (hit_v_q) begin
                valid_q[hit_idx_q] <= 1'b0;
                out_q              <= close_item(StDone, 1'b0);
              end else begin
                out_q <= close_item(StIgnored, 1'b0);
              end
            end
            OpReduce: begin
              if (hit_v_q) begin
                if (red_qty[63] || red_qty == 64'd0) begin
                  valid_q[hit_idx_q] <= 1'b0;
                end
                out_q <= close_item(StDone, 1'b0);
              end else begin
                out_q <= close_item(StIgnored, 1'b0);
              end
            end
            OpQuery: begin
              out_q <= close_item(StDone, hit_v_q);
            end
            OpQuote, OpTrade: begin
              out_q <= close_item(StDone, 1'b0);
            end
            default: begin
              out_q <= close_item(StIgnored, 1'b0);
            end
          endcase
          // Hold the closing item back while marked fills are still to go out.
          if ((req_q.operation == OpQuote || req_q.operation == OpTrade) && (|mark_q)) begin
            cnt_q    <= '0;
            pv_q     <= 1'b0;
            best_v_q <= 1'b0;
            state_q  <= S_SEL;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_CLOSE;
          end
        end
        S_SEL: begin
          if (cnt_q != MaxCnt) begin
            cnt_q <= cnt_q + 1'b1;
          end
          pv_q   <= (cnt_q != MaxCnt);
          pidx_q <= cnt_q[IdxW-1:0];
          if (pv_q && mark_q[pidx_q] && better) begin
            best_v_q     <= 1'b1;
            best_idx_q   <= pidx_q;
            best_price_q <= rd_q.price;
            best_arr_q   <= rd_q.arrival;
            best_id_q    <= rd_q.id;
            best_qty_q   <= rd_q.quantity;
            best_fp_q    <= attr_q[pidx_q] ? req_q.price : rd_q.price;
          end
          if (scan_done) begin
            out_q       <= '{is_fill: 1'b1, fill_order_id: best_id_q,
                             fill_price: best_fp_q, fill_quantity: best_qty_q,
                             status: StDone, found: 1'b0, last: 1'b0};
            out_valid_q <= 1'b1;
            state_q     <= S_FILL;
          end
        end
        S_FILL: begin
          if (out_ready_i) begin
            mark_q[best_idx_q]  <= 1'b0;
            valid_q[best_idx_q] <= 1'b0;
            if (|mark_rest) begin
              out_valid_q <= 1'b0;
              cnt_q       <= '0;
              pv_q        <= 1'b0;
              best_v_q    <= 1'b0;
              state_q     <= S_SEL;
            end else begin
              out_q   <= close_item(StDone, 1'b0);
              state_q <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/obfs_checker.sv */
// Port-level checker for the order book fill simulator, bound to the top level.
// Depends on obfs_pkg for the result type.
`timescale 1ns / 1ps

module obfs_checker
  import obfs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_res_t out_data_o
);

  // No new request is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a result is pending");

  // Ready is low in the cycle after a request is accepted.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after a request");

  // A fill is never the closing item, and the closing item is never a fill.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_fill != out_data_o.last))
    else $error("fill and closing flags disagree");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result dropped or changed");

endmodule

bind order_book_fill_simulator_unit obfs_checker u_obfs_checker (.*);
